// File: rtl/crh_pkg.sv
// crh_pkg: shared types, constants and helpers for the cyclic polynomial rolling hash.
// Holds the 256-word random table, the left-rotate helper and the queue entry type.
// No dependencies.
package crh_pkg;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 7;
    localparam int ROT_W  = 5;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic {
        CMD_HASH    = 1'b0,
        CMD_RESTART = 1'b1
    } t_command;

    // one queue slot between front and back
    typedef struct packed {
        logic              restart;
        logic [HASH_W-1:0] word_add;
        logic [HASH_W-1:0] word_remove;
        logic              window_full;
    } t_queue_entry;

    localparam logic [HASH_W-1:0] WORD_TABLE [256] = '{
        32'h2ce500a9, 32'he87b7d58, 32'h962a06bb, 32'h2ae6cd5b,
        32'hebbe526f, 32'h649fb074, 32'hab3ca458, 32'h732d093c,
        32'h984cb38d, 32'h09320fd2, 32'hcfdcf19e, 32'h22bcec60,
        32'h5fbb0a59, 32'h55a8e6b2, 32'h59aed289, 32'h7c0aabf9,
        32'h01e7e544, 32'hda961641, 32'h71076ddb, 32'h9b04388c,
        32'he56a9a8d, 32'h952f9cff, 32'hce762621, 32'h67fe6d8e,
        32'h056de50a, 32'h1e67957e, 32'h9aa9c754, 32'h5a629851,
        32'h9095e8d8, 32'h3f5f317e, 32'h92377bf3, 32'hc106db94,
        32'h7107eac7, 32'hc714c98d, 32'h44bcf843, 32'hae040d53,
        32'hfa2f361f, 32'h1b7a9471, 32'h5b140e07, 32'h47d7cba6,
        32'hec3523d7, 32'h8db15be7, 32'h28be309d, 32'h48dc54f4,
        32'h8de61241, 32'h4add1dc3, 32'h92956ce4, 32'h61771c9a,
        32'h906c99e0, 32'h19f9f585, 32'hd9767e1a, 32'h7a7ad68b,
        32'h5f0ae888, 32'hf5270a15, 32'h7ad6d55d, 32'haffec476,
        32'hbb507688, 32'h8e514a6d, 32'h47f35e87, 32'hd88c916b,
        32'hb24dcdf8, 32'h0da7a2ac, 32'hc128e78d, 32'hf708f5dc,
        32'h82e5d37e, 32'h85bb9296, 32'he0cd290c, 32'hae9579c0,
        32'h0b6ef49c, 32'h827bf8f4, 32'h9228f233, 32'haedc02c6,
        32'h7361bade, 32'h461b7c03, 32'hea84fa7d, 32'h6b58c278,
        32'h8c852dc4, 32'ha24979fe, 32'h827d45e1, 32'h93e0a3a9,
        32'h9e9563d0, 32'h1feae878, 32'h21074d0a, 32'h53aa401f,
        32'hb7bb907b, 32'h176308f0, 32'hc9b97562, 32'h3253fadc,
        32'hdb01ff0e, 32'h496fc0bc, 32'h2aabeec5, 32'hb56c7299,
        32'ha335dcab, 32'h0cde0647, 32'h818e8012, 32'haca82273,
        32'hc157a5a4, 32'ha3c591a6, 32'h2b4d1304, 32'h95327423,
        32'hb4a3ac1f, 32'h42ad1dea, 32'hb7576169, 32'h14360b29,
        32'h98a5c002, 32'h20dcd620, 32'hf204d994, 32'h1a00b025,
        32'h1474b167, 32'hf24b2a96, 32'h9acdbb49, 32'h0bce6da6,
        32'h8959c059, 32'hee4e549f, 32'h64206b22, 32'h832ce76c,
        32'h63901128, 32'h02b64403, 32'h8199ac5e, 32'h54f6f884,
        32'hc74004cf, 32'hbe8f7ba3, 32'hf74bd943, 32'hbefa4889,
        32'h4565b40f, 32'h985cca23, 32'h39a370c1, 32'h8ab64ad0,
        32'hce9d1955, 32'hc12bc20e, 32'h8c1aac30, 32'hb8332d69,
        32'hd3aa2d49, 32'hb071df5d, 32'h36027c47, 32'h0afd98a9,
        32'hd1ed3148, 32'hdfd3068e, 32'h847cdbc6, 32'hbd165c8e,
        32'h620df09e, 32'h463fa7c5, 32'h56bde067, 32'h75a4dc34,
        32'h33a3758a, 32'h7514bfc0, 32'h81f7b5c1, 32'h00860bea,
        32'h8cdfe550, 32'he7fa1586, 32'h4432fba8, 32'hb9fbf5f8,
        32'hab5dbbb3, 32'hfc5695e3, 32'hf63321b5, 32'hd7addab8,
        32'he94d1045, 32'h35285a59, 32'h1c0c7d97, 32'h558283f1,
        32'h7ae094d3, 32'h2c55eed5, 32'h8df52667, 32'hd6661582,
        32'heb16324a, 32'h512ff7b8, 32'h75bb193e, 32'h0073b3d2,
        32'h34a28dc1, 32'h156f0b72, 32'h76a04dff, 32'hd8ee951b,
        32'hefc90501, 32'h3d549bcf, 32'h9bbcb0ef, 32'h276b02dd,
        32'h2583d24f, 32'h01d99492, 32'h1900d354, 32'hac860923,
        32'h2665a45b, 32'h05ff74dd, 32'h7a747116, 32'h07825514,
        32'hfbc8f199, 32'h27383cf7, 32'h6b29b61c, 32'hf813591a,
        32'h61128fea, 32'h62e2d8a2, 32'had4d162a, 32'hfb80234c,
        32'h0c3dacbf, 32'ha46d9030, 32'h70bc6434, 32'h15c3e792,
        32'h93587817, 32'hf7cfa859, 32'hc55b51e5, 32'hf5701574,
        32'h350859b2, 32'h1907f63e, 32'h937bbd16, 32'hc84c9f33,
        32'he21f35c2, 32'h2e5130d1, 32'h944c8a99, 32'hfdacb64f,
        32'h3685bf89, 32'h0a2061a9, 32'hdc91746a, 32'h28fa0a8c,
        32'ha040ed1c, 32'h9109b224, 32'h7ad00356, 32'hba206d1a,
        32'hcbaf338c, 32'h1817ad9b, 32'h560d0621, 32'h16624850,
        32'h3f2fce50, 32'hfb60bd41, 32'h1ef2d6d9, 32'h00ec6323,
        32'h25344935, 32'h55e8d698, 32'hd656a827, 32'h963295b3,
        32'hcd88b6f1, 32'h8fae853a, 32'h824c6e31, 32'h5233092c,
        32'hbceb1741, 32'he26dd81c, 32'hc8b00ee9, 32'h15ffdbce,
        32'h1cab44ca, 32'h1598e9a4, 32'h3e325fa6, 32'hc7565fd1,
        32'hafbefe00, 32'he100a0e7, 32'h328f6295, 32'h8c5361dd,
        32'h873b16c0, 32'hda205989, 32'had05f250, 32'hd1dec8c4,
        32'hf5bc1d9b, 32'h050e29f4, 32'hbc0f68b8, 32'h2615a149,
        32'hc796d2fb, 32'h286fe4ae, 32'h2860fd18, 32'h961174ce
    };

    function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] v,
                                               input logic [ROT_W-1:0]  amt);
        logic [2*HASH_W-1:0] d;
        d = {v, v} << amt;
        return d[2*HASH_W-1:HASH_W];
    endfunction

endpackage

// File: rtl/crh_front.sv
// crh_front: accepts items, tracks window position and fill state, owns the window store.
// Looks up and pre-rotates the table words, then hands each item to the queue.
// Depends on crh_pkg.
module crh_front
    import crh_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CFG_W-1:0]   i_window_size,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [BYTE_W-1:0]  i_byte_in,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_queue_entry       o_push_entry
);

    localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SZ_W = ($clog2(MAX_WINDOW + 1) > CFG_W) ? $clog2(MAX_WINDOW + 1) : CFG_W;

    logic [PW-1:0]     r_pos, n_pos;
    logic              r_filled, n_filled;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_restart;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_remove;
    logic [ROT_W-1:0]  r_s1_rot;
    logic              r_s1_full;
    logic [BYTE_W-1:0] r_old_byte;
    logic [BYTE_W-1:0] r_window [MAX_WINDOW];

    logic              accept;
    logic              is_restart;
    logic [SZ_W-1:0]   size_ext;
    logic [SZ_W-1:0]   eff_size;
    logic [SZ_W-1:0]   pos_inc;
    logic              wrap;

    assign o_ready    = !r_s1_valid || i_push_ready;
    assign accept     = i_valid && o_ready;
    assign is_restart = (t_command'(i_command) == CMD_RESTART);

    // zero acts as one, anything beyond the store depth saturates
    always_comb begin
        size_ext = SZ_W'(i_window_size);
        if (size_ext == '0) begin
            eff_size = SZ_W'(1);
        end else if (size_ext > SZ_W'(MAX_WINDOW)) begin
            eff_size = SZ_W'(MAX_WINDOW);
        end else begin
            eff_size = size_ext;
        end
    end

    assign pos_inc = SZ_W'(r_pos) + SZ_W'(1);
    assign wrap    = (pos_inc >= eff_size);

    always_comb begin
        n_pos      = r_pos;
        n_filled   = r_filled;
        n_s1_valid = r_s1_valid;
        if (r_s1_valid && i_push_ready) begin
            n_s1_valid = 1'b0;
        end
        if (accept) begin
            n_s1_valid = 1'b1;
            if (is_restart) begin
                n_pos    = '0;
                n_filled = 1'b0;
            end else if (wrap) begin
                n_pos    = '0;
                n_filled = 1'b1;
            end else begin
                n_pos    = pos_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_filled   <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_filled   <= n_filled;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_restart <= is_restart;
            r_s1_byte    <= i_byte_in;
            r_s1_remove  <= r_filled && !is_restart;
            r_s1_rot     <= eff_size[ROT_W-1:0];
            r_s1_full    <= n_filled;
        end
    end

    // window store: read-first, so the old byte at this position comes out
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old_byte <= r_window[r_pos];
            if (!is_restart) begin
                r_window[r_pos] <= i_byte_in;
            end
        end
    end

    assign o_push_valid             = r_s1_valid;
    assign o_push_entry.restart     = r_s1_restart;
    assign o_push_entry.word_add    = WORD_TABLE[r_s1_byte];
    assign o_push_entry.word_remove = r_s1_remove ? rotl(WORD_TABLE[r_old_byte], r_s1_rot)
                                                  : '0;
    assign o_push_entry.window_full = r_s1_full;

endmodule

// File: rtl/crh_queue.sv
// crh_queue: two-slot queue between the front and the back.
// Depends on crh_pkg for the entry type.
module crh_queue
    import crh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  t_queue_entry i_push_entry,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output t_queue_entry o_pop_entry
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    t_queue_entry    r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [AW:0]     r_count, n_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_entry  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (pop && !push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: rtl/crh_back.sv
// crh_back: holds the running hash, folds in each queued item and drives the result register.
// Depends on crh_pkg.
module crh_back
    import crh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  t_queue_entry       i_pop_entry,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [HASH_W-1:0]  o_hash,
    output logic               o_window_full
);

    logic              r_out_valid, n_out_valid;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic              r_full, n_full;
    logic              pop;

    assign o_pop_ready = !r_out_valid || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_hash      = r_hash;
        n_full      = r_full;
        if (pop) begin
            n_out_valid = 1'b1;
            n_full      = i_pop_entry.window_full;
            if (i_pop_entry.restart) begin
                n_hash = '0;
            end else begin
                n_hash = rotl(r_hash, ROT_W'(1)) ^ i_pop_entry.word_add
                         ^ i_pop_entry.word_remove;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hash      <= '0;
            r_full      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            r_full      <= n_full;
        end
    end

    // the hash register doubles as the result register
    assign o_valid       = r_out_valid;
    assign o_hash        = r_hash;
    assign o_window_full = r_full;

endmodule

// File: rtl/cyclic_polynomial_rolling_hash.sv
// Top level of the 32-bit cyclic polynomial (buzhash style) rolling hash over a byte window.
// Instantiates crh_front, crh_queue and crh_back; depends on crh_pkg.
//
// One item (a byte to hash, or a restart) is taken per clock while o_in_ready is high and gives
// exactly one result: the hash after that step and a flag that is set once window_size bytes
// have gone in since the last restart. Sustained rate is one item per cycle while the output is
// taken; a result passes the front stage with the window store read, the two-slot queue and the
// hash register before it is offered. The rate is set by the rotate-and-XOR loop on the hash
// register and the single read/write port of the window store. The window store has no reset and
// its old bytes are only used at positions written since the last restart; after changing
// window_size, issue a restart. Window size 0 acts as 1, sizes above MAX_WINDOW saturate.
// Configuration writes are taken at any time but must only be made while idle.
module cyclic_polynomial_rolling_hash
    import crh_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_window_size,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [BYTE_W-1:0]  i_byte_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [HASH_W-1:0]  o_hash,
    output logic               o_window_full
);

    logic [CFG_W-1:0] r_window_size;
    logic             q_push_valid;
    logic             q_push_ready;
    t_queue_entry     q_push_entry;
    logic             q_pop_valid;
    logic             q_pop_ready;
    t_queue_entry     q_pop_entry;
    logic             q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_window_size <= i_window_size;
        end
    end

    crh_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window_size(r_window_size),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_command    (i_command),
        .i_byte_in    (i_byte_in),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_push_entry (q_push_entry)
    );

    crh_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(q_push_valid),
        .o_push_ready(q_push_ready),
        .i_push_entry(q_push_entry),
        .o_pop_valid (q_pop_valid),
        .i_pop_ready (q_pop_ready),
        .o_pop_entry (q_pop_entry)
    );

    crh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (q_pop_valid),
        .o_pop_ready  (q_pop_ready),
        .i_pop_entry  (q_pop_entry),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_hash       (o_hash),
        .o_window_full(o_window_full)
    );

    assign q_pop = q_pop_valid && q_pop_ready;

`ifndef SYNTHESIS
    // a restart reaching the back gives a zero hash and an empty window next cycle
    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop && q_pop_entry.restart |=> o_out_valid && (o_hash == '0) && !o_window_full)
        else $error("restart did not produce a cleared result");

    // a pending result is never overwritten before its transfer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

    // input back-pressure comes only from a full queue behind the front stage
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_push_valid && !q_push_ready)
        else $error("input stalled without a full queue");

    // the full flag only comes up on a hashed byte
    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_window_full) |-> $past(q_pop && !q_pop_entry.restart))
        else $error("window_full rose without a byte transfer");
`endif

endmodule
